// ===== design/spn_pkg.sv =====
// shared types, constants and round functions for the 16-bit spn block cipher
package spn_pkg;

  localparam int BLOCK_W    = 16;
  localparam int NIBBLE_W   = 4;
  localparam int NUM_NIBBLE = BLOCK_W / NIBBLE_W;
  localparam int CFG_IDX_W  = 2;
  localparam int ROUND_W    = 2;
  localparam int MAX_ROUNDS = 3;
  localparam int NUM_STAGES = 3;

  // reset values of the configuration registers
  localparam logic [BLOCK_W-1:0] KEY_FIRST_RST  = 16'h3A94;
  localparam logic [BLOCK_W-1:0] KEY_SECOND_RST = 16'hA944;
  localparam logic [BLOCK_W-1:0] KEY_THIRD_RST  = 16'h4DBB;
  localparam logic [ROUND_W-1:0] ROUND_TOTAL_RST = 2'd3;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_KEY_FIRST   = 2'd0,
    CFG_KEY_SECOND  = 2'd1,
    CFG_KEY_THIRD   = 2'd2,
    CFG_ROUND_TOTAL = 2'd3
  } cfg_idx_t;

  // one pipeline slot: valid bit travelling with its block
  typedef struct packed {
    logic               valid;
    logic [BLOCK_W-1:0] block;
  } stage_t;

  // output position j (from the first bit) takes input position PERM[j]
  localparam logic [4:0] PERM [16] = '{
    5'd3, 5'd2, 5'd16, 5'd1, 5'd15, 5'd11, 5'd4, 5'd7,
    5'd8, 5'd13, 5'd9, 5'd10, 5'd14, 5'd5, 5'd12, 5'd6
  };

  // s-box kept as specified, including the repeated 9
  localparam logic [NIBBLE_W-1:0] SBOX [16] = '{
    4'd14, 4'd4, 4'd13, 4'd1, 4'd2, 4'd15, 4'd11, 4'd8,
    4'd9, 4'd10, 4'd6, 4'd12, 4'd5, 4'd9, 4'd0, 4'd7
  };

  // nibble-wise substitution
  function automatic logic [BLOCK_W-1:0] substitute(input logic [BLOCK_W-1:0] v);
    logic [BLOCK_W-1:0] r;
    r = '0;
    for (int n = 0; n < NUM_NIBBLE; n++) begin
      r[n*NIBBLE_W +: NIBBLE_W] = SBOX[v[n*NIBBLE_W +: NIBBLE_W]];
    end
    return r;
  endfunction

  // fixed bit permutation, first bit is bit 15
  function automatic logic [BLOCK_W-1:0] permute(input logic [BLOCK_W-1:0] v);
    logic [BLOCK_W-1:0] r;
    logic [3:0]         src;
    r   = '0;
    src = '0;
    for (int j = 0; j < BLOCK_W; j++) begin
      src = 4'(5'd16 - PERM[j]);
      r[BLOCK_W-1-j] = v[src];
    end
    return r;
  endfunction

endpackage

// ===== design/spn_plain_if.sv =====
// plaintext request channel
interface spn_plain_if;
  logic                         valid;
  logic                         ready;
  logic [spn_pkg::BLOCK_W-1:0]  plain_block;

  modport source (output valid, output plain_block, input ready);
  modport sink   (input valid, input plain_block, output ready);
endinterface

// ===== design/spn_cipher_if.sv =====
// ciphertext request channel
interface spn_cipher_if;
  logic                         valid;
  logic                         ready;
  logic [spn_pkg::BLOCK_W-1:0]  cipher_block;

  modport source (output valid, output cipher_block, input ready);
  modport sink   (input valid, input cipher_block, output ready);
endinterface

// ===== design/spn_cfg_if.sv =====
// configuration write channel
interface spn_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [spn_pkg::CFG_IDX_W-1:0]  index;
  logic [spn_pkg::BLOCK_W-1:0]    data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== design/spn_round.sv =====
// one registered round stage: key mix, substitution and permutation
module spn_round (
  input  logic                        clk,
  input  logic                        rst,
  input  spn_pkg::stage_t             in_stage,
  output logic                        in_ready,
  input  logic [spn_pkg::BLOCK_W-1:0] key,
  input  logic                        enable,
  output spn_pkg::stage_t             out_stage,
  input  logic                        out_ready
);

  logic                         q_valid;
  logic [spn_pkg::BLOCK_W-1:0]  q_block;
  logic [spn_pkg::BLOCK_W-1:0]  round_out;

  // round function, bypassed when this round is not configured
  always_comb begin
    if (enable) begin
      round_out = spn_pkg::permute(spn_pkg::substitute(in_stage.block ^ key));
    end else begin
      round_out = in_stage.block;
    end
  end

  // slot takes a new request when empty or when its content moves on
  assign in_ready = !q_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      q_valid <= 1'b0;
    end else if (in_ready) begin
      q_valid <= in_stage.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_stage.valid) begin
      q_block <= round_out;
    end
  end

  assign out_stage = {q_valid, q_block};

endmodule

// ===== design/spn_block_encrypt_16bit_core.sv =====
// top level of the 16-bit spn block cipher: config registers and round pipeline
//
//  channel  | direction | payload                 | handshake
//  ---------+-----------+-------------------------+------------
//  cfg      | in        | index[1:0], data[15:0]  | valid/ready
//  plain    | in        | plain_block[15:0]       | valid/ready
//  cipher   | out       | cipher_block[15:0]      | valid/ready
//
// three register stages, one per round; an accepted block passes the first, second
// and third stage registers in order before it is offered on the output;
// a new block can be accepted every cycle while the output is not stalled.
// rounds beyond the configured count pass the block through unchanged.
// synchronous reset empties the pipeline, restores the default keys and holds
// both input channels off.
// a stalled output holds; empty slots further up still fill, so nothing is lost.
// configuration writes are accepted in every cycle outside reset.
module spn_block_encrypt_16bit_core (
  input  logic                clk,
  input  logic                rst,
  spn_cfg_if.sink             cfg,
  spn_plain_if.sink           plain,
  spn_cipher_if.source        cipher
);

  logic [spn_pkg::BLOCK_W-1:0] round_key_first;
  logic [spn_pkg::BLOCK_W-1:0] round_key_second;
  logic [spn_pkg::BLOCK_W-1:0] round_key_third;
  logic [spn_pkg::ROUND_W-1:0] round_total;
  logic [spn_pkg::ROUND_W-1:0] round_eff;

  logic [spn_pkg::BLOCK_W-1:0] keys      [spn_pkg::NUM_STAGES];
  spn_pkg::stage_t             stage_in  [spn_pkg::NUM_STAGES];
  spn_pkg::stage_t             stage_out [spn_pkg::NUM_STAGES];
  logic                        stage_rdy [spn_pkg::NUM_STAGES];
  logic                        down_rdy  [spn_pkg::NUM_STAGES];

  // configuration writes
  assign cfg.ready = !rst;

  always_ff @(posedge clk) begin
    if (rst) begin
      round_key_first  <= spn_pkg::KEY_FIRST_RST;
      round_key_second <= spn_pkg::KEY_SECOND_RST;
      round_key_third  <= spn_pkg::KEY_THIRD_RST;
      round_total      <= spn_pkg::ROUND_TOTAL_RST;
    end else if (cfg.valid && cfg.ready) begin
      unique case (spn_pkg::cfg_idx_t'(cfg.index))
        spn_pkg::CFG_KEY_FIRST:   round_key_first  <= cfg.data;
        spn_pkg::CFG_KEY_SECOND:  round_key_second <= cfg.data;
        spn_pkg::CFG_KEY_THIRD:   round_key_third  <= cfg.data;
        spn_pkg::CFG_ROUND_TOTAL: round_total      <= cfg.data[spn_pkg::ROUND_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // round count saturates at the maximum
  assign round_eff = (round_total > spn_pkg::ROUND_W'(spn_pkg::MAX_ROUNDS))
                   ? spn_pkg::ROUND_W'(spn_pkg::MAX_ROUNDS) : round_total;

  assign keys[0] = round_key_first;
  assign keys[1] = round_key_second;
  assign keys[2] = round_key_third;

  // pipeline head
  assign stage_in[0].valid = plain.valid;
  assign stage_in[0].block = plain.plain_block;
  assign plain.ready       = stage_rdy[0] && !rst;

  // round stages
  for (genvar i = 0; i < spn_pkg::NUM_STAGES; i++) begin : g_round
    if (i > 0) begin : g_link
      assign stage_in[i]  = stage_out[i-1];
      assign down_rdy[i-1] = stage_rdy[i];
    end

    spn_round u_round (
      .clk       (clk),
      .rst       (rst),
      .in_stage  (stage_in[i]),
      .in_ready  (stage_rdy[i]),
      .key       (keys[i]),
      .enable    (round_eff > spn_pkg::ROUND_W'(i)),
      .out_stage (stage_out[i]),
      .out_ready (down_rdy[i])
    );
  end

  // pipeline tail drives the result channel
  assign down_rdy[spn_pkg::NUM_STAGES-1] = cipher.ready;
  assign cipher.valid        = stage_out[spn_pkg::NUM_STAGES-1].valid;
  assign cipher.cipher_block = stage_out[spn_pkg::NUM_STAGES-1].block;

endmodule

// ===== design/spn_chk.sv =====
// port-level checks for the spn block cipher core
module spn_chk (
  input logic                        clk,
  input logic                        rst,
  input logic                        cfg_ready,
  input logic                        in_valid,
  input logic                        in_ready,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [spn_pkg::BLOCK_W-1:0] cipher_block
);

  // stalled result stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result withdrawn while stalled");

  // stalled result keeps its value
  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(cipher_block))
    else $error("result changed while stalled");

  // pipeline empty after reset
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result offered straight after reset");

  // an accepted block reaches the output through the stage registers when the output drains
  a_latency: assert property (@(posedge clk)
    !rst && !$past(rst) && !$past(rst, 2) && !$past(rst, 3)
    && $past(in_valid && in_ready, 3) && $past(out_ready, 2) && $past(out_ready)
    |-> out_valid)
    else $error("accepted block missing at the output");

  // configuration port never stalls
  a_cfg_ready: assert property (@(posedge clk) disable iff (rst)
    cfg_ready)
    else $error("configuration port stalled");

endmodule

bind spn_block_encrypt_16bit_core spn_chk u_spn_chk (
  .clk          (clk),
  .rst          (rst),
  .cfg_ready    (cfg.ready),
  .in_valid     (plain.valid),
  .in_ready     (plain.ready),
  .out_valid    (cipher.valid),
  .out_ready    (cipher.ready),
  .cipher_block (cipher.cipher_block)
);

// ===== sim/spn_cipher_checker.sv =====
// checker for the 16-bit spn cipher: tracks the key registers, predicts and compares ciphertext
`timescale 1ns / 100ps

module spn_cipher_checker (
  input  logic  clk,
  input  logic  rst,
  spn_cfg_if    cfg,
  spn_plain_if  plain,
  spn_cipher_if cipher,
  output int    fail_count,
  output int    pending
);

  // substitution table, repeated 9 included
  localparam int SUBST_TAB [16] = '{14, 4, 13, 1, 2, 15, 11, 8, 9, 10, 6, 12, 5, 9, 0, 7};
  // output position j (first bit is position 1) takes input position WIRE_TAB[j]
  localparam int WIRE_TAB [16] = '{3, 2, 16, 1, 15, 11, 4, 7, 8, 13, 9, 10, 14, 5, 12, 6};
  localparam int REPORT_MAX = 10;

  typedef struct {
    logic [spn_pkg::BLOCK_W-1:0] src;
    logic [spn_pkg::BLOCK_W-1:0] ct;
  } cipher_due_t;

  cipher_due_t                 cipher_due [$];
  logic [spn_pkg::BLOCK_W-1:0] round_key [3];
  logic [spn_pkg::ROUND_W-1:0] round_count;
  int                          fails;

  // ciphertext the block should give for one plaintext under the current keys
  function automatic logic [spn_pkg::BLOCK_W-1:0] encipher_block(
    input logic [spn_pkg::BLOCK_W-1:0] src);
    logic [spn_pkg::BLOCK_W-1:0] state;
    logic [spn_pkg::BLOCK_W-1:0] mixed;
    int                          rounds;
    state  = src;
    rounds = (int'(round_count) > spn_pkg::MAX_ROUNDS) ? spn_pkg::MAX_ROUNDS
                                                       : int'(round_count);
    for (int r = 0; r < rounds && r < 3; r++) begin
      mixed = state ^ round_key[r];
      for (int n = 0; n < spn_pkg::NUM_NIBBLE; n++) begin
        mixed[n*spn_pkg::NIBBLE_W +: spn_pkg::NIBBLE_W] =
          spn_pkg::NIBBLE_W'(SUBST_TAB[mixed[n*spn_pkg::NIBBLE_W +: spn_pkg::NIBBLE_W]]);
      end
      for (int j = 0; j < spn_pkg::BLOCK_W; j++) begin
        state[spn_pkg::BLOCK_W-1-j] = mixed[spn_pkg::BLOCK_W - WIRE_TAB[j]];
      end
    end
    return state;
  endfunction

  // watch all three channels on each edge
  always @(posedge clk) begin
    cipher_due_t head;
    cipher_due_t fresh;
    if (rst) begin
      round_key[0] = spn_pkg::KEY_FIRST_RST;
      round_key[1] = spn_pkg::KEY_SECOND_RST;
      round_key[2] = spn_pkg::KEY_THIRD_RST;
      round_count  = spn_pkg::ROUND_TOTAL_RST;
      cipher_due.delete();
      fails = 0;
    end else begin
      // register writes
      if (cfg.valid && cfg.ready) begin
        case (spn_pkg::cfg_idx_t'(cfg.index))
          spn_pkg::CFG_KEY_FIRST:   round_key[0] = cfg.data;
          spn_pkg::CFG_KEY_SECOND:  round_key[1] = cfg.data;
          spn_pkg::CFG_KEY_THIRD:   round_key[2] = cfg.data;
          spn_pkg::CFG_ROUND_TOTAL: round_count  = cfg.data[spn_pkg::ROUND_W-1:0];
          default: ;
        endcase
      end
      // plaintext request accepted: queue its ciphertext
      if (plain.valid && plain.ready) begin
        fresh.src = plain.plain_block;
        fresh.ct  = encipher_block(plain.plain_block);
        cipher_due.push_back(fresh);
      end
      // ciphertext request accepted: compare with the oldest expectation
      if (cipher.valid && cipher.ready) begin
        if (cipher_due.size() == 0) begin
          fails++;
          if (fails <= REPORT_MAX) begin
            $display("chk: unexpected ciphertext %h", cipher.cipher_block);
          end
        end else begin
          head = cipher_due.pop_front();
          if (head.ct !== cipher.cipher_block) begin
            fails++;
            if (fails <= REPORT_MAX) begin
              $display("chk: plaintext %h expected %h got %h",
                       head.src, head.ct, cipher.cipher_block);
            end
          end
        end
      end
    end
    fail_count <= fails;
    pending    <= cipher_due.size();
  end

endmodule

// ===== sim/tb.sv =====
// top of the spn cipher testbench: clock, reset, stimulus, receiver stalls and verdict
`timescale 1ns / 100ps

module tb;

  localparam int CYCLE_LIMIT  = 200000;
  localparam int PHASES       = 10;
  localparam int PHASE_BLOCKS = 124;
  localparam int LONG_HOLD    = 60;
  localparam int SETTLE_CYC   = 6;

  logic clk;
  logic rst;
  int   cycles = 0;
  int   fail_count;
  int   pending;
  int   blocks_sent = 0;
  int   settings_used = 0;
  logic sender_steady = 1'b0;

  spn_cfg_if    cfg_ch ();
  spn_plain_if  plain_ch ();
  spn_cipher_if cipher_ch ();

  spn_block_encrypt_16bit_core dut (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg_ch),
    .plain  (plain_ch),
    .cipher (cipher_ch)
  );

  spn_cipher_checker chk (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg_ch),
    .plain      (plain_ch),
    .cipher     (cipher_ch),
    .fail_count (fail_count),
    .pending    (pending)
  );

  // 4 ns clock
  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  // run limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("tb: cycle limit reached with %0d ciphertexts outstanding", pending);
      $display("tb: errors");
      $finish;
    end
  end

  // one register write, valid left high for a following write
  task automatic write_reg(input spn_pkg::cfg_idx_t idx,
                           input logic [spn_pkg::BLOCK_W-1:0] value);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= value;
    do @(posedge clk); while (!cfg_ch.ready);
  endtask

  // all four registers back to back
  task automatic set_config(input logic [spn_pkg::BLOCK_W-1:0] k1,
                            input logic [spn_pkg::BLOCK_W-1:0] k2,
                            input logic [spn_pkg::BLOCK_W-1:0] k3,
                            input logic [spn_pkg::ROUND_W-1:0] rounds);
    write_reg(spn_pkg::CFG_KEY_FIRST, k1);
    write_reg(spn_pkg::CFG_KEY_SECOND, k2);
    write_reg(spn_pkg::CFG_KEY_THIRD, k3);
    write_reg(spn_pkg::CFG_ROUND_TOTAL, spn_pkg::BLOCK_W'(rounds));
    cfg_ch.valid <= 1'b0;
    settings_used++;
  endtask

  // offer one plaintext request after a random gap
  task automatic send_block(input logic [spn_pkg::BLOCK_W-1:0] value);
    int gap;
    gap = sender_steady ? 0 : $urandom_range(0, 9);
    if (gap != 0) begin
      plain_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    plain_ch.valid       <= 1'b1;
    plain_ch.plain_block <= value;
    do @(posedge clk); while (!plain_ch.ready);
    blocks_sent++;
  endtask

  // stop offering and wait for every outstanding ciphertext
  task automatic settle();
    plain_ch.valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (SETTLE_CYC) @(posedge clk);
  endtask

  function automatic logic [spn_pkg::BLOCK_W-1:0] random_key();
    int pick;
    pick = $urandom_range(0, 9);
    if (pick == 0) return '0;
    if (pick == 1) return '1;
    return spn_pkg::BLOCK_W'($urandom_range(0, 65535));
  endfunction

  function automatic logic [spn_pkg::BLOCK_W-1:0] random_plain();
    int pick;
    pick = $urandom_range(0, 15);
    if (pick == 0) return '0;
    if (pick == 1) return '1;
    if (pick == 2) return spn_pkg::BLOCK_W'(1) << $urandom_range(0, spn_pkg::BLOCK_W - 1);
    return spn_pkg::BLOCK_W'($urandom_range(0, 65535));
  endfunction

  // receiver: random stalls, stall-free stretches, two long hold-offs
  initial begin : cipher_sink
    int gap;
    int taken;
    taken = 0;
    cipher_ch.ready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      gap = ((taken / 150) % 4 == 1) ? 0 : $urandom_range(0, 9);
      if (taken == 300 || taken == 800) gap = LONG_HOLD;
      if (gap != 0) begin
        cipher_ch.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      cipher_ch.ready <= 1'b1;
      do @(posedge clk); while (!(cipher_ch.valid && cipher_ch.ready));
      taken++;
    end
  end

  // stimulus
  initial begin : stimulus
    logic [spn_pkg::ROUND_W-1:0] rounds;
    rst                  <= 1'b1;
    cfg_ch.valid         <= 1'b0;
    cfg_ch.index         <= spn_pkg::CFG_KEY_FIRST;
    cfg_ch.data          <= '0;
    plain_ch.valid       <= 1'b0;
    plain_ch.plain_block <= '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset keys, three rounds
    send_block(16'h0000);
    send_block(16'hFFFF);
    send_block(16'h8001);
    send_block(16'h7FFE);
    settle();

    // zero rounds passes the block straight through
    set_config(16'h0000, 16'h0000, 16'h0000, 2'd0);
    send_block(16'hFFFF);
    send_block(16'h1234);
    settle();

    // one round with a zero key: every s-box entry once
    set_config(16'h0000, 16'hFFFF, 16'hFFFF, 2'd1);
    send_block(16'h0123);
    send_block(16'h4567);
    send_block(16'h89AB);
    send_block(16'hCDEF);
    settle();

    // two rounds with all-ones keys, then three rounds with all-ones and zero keys
    set_config(16'hFFFF, 16'hFFFF, 16'h0000, 2'd2);
    send_block(16'h0000);
    send_block(16'hFFFF);
    settle();
    set_config(16'hFFFF, 16'h0000, 16'hFFFF, 2'd3);
    send_block(16'h0000);
    send_block(16'hFFFF);
    send_block(16'hA5C3);
    settle();

    // random phases, each under its own key and round setting
    for (int p = 0; p < PHASES; p++) begin
      rounds = spn_pkg::ROUND_W'(p % 4);
      if (p == 0) begin
        set_config('0, '0, '0, rounds);
      end else if (p == 1) begin
        set_config('1, '1, '1, rounds);
      end else begin
        set_config(random_key(), random_key(), random_key(), rounds);
      end
      sender_steady = (p % 3 == 2);
      for (int i = 0; i < PHASE_BLOCKS; i++) begin
        // one mid-stream pause until everything has come out
        if (p == 4 && i == PHASE_BLOCKS / 2) settle();
        send_block(random_plain());
      end
      settle();
    end

    $display("tb: %0d plaintext blocks under %0d key settings, round counts 0 to 3",
             blocks_sent, settings_used);
    $display("tb: receiver held off twice for %0d cycles, sender drained mid-stream",
             LONG_HOLD);
    if (fail_count == 0 && pending == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

endmodule
